// ===== rtl/ssm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults for the sorted stream merge block.
// Used by ssm_ctrl, ssm_datapath, sorted_stream_merge_core and ssm_checker.
package ssm_pkg;

    localparam int DATA_W               = 32;
    localparam int OP_W                 = 2;
    localparam int STAT_W               = 2;
    localparam int DEFAULT_BUFFER_DEPTH = 16;
    localparam int DEFAULT_VALUE_WIDTH  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_END_FIRST   = 2'd2,
        OP_END_SECOND  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ELEM    = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_REFUSED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFUSE,
        ST_FETCH,
        ST_EVAL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_elem;
        logic load_empty;
        logic load_refuse;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic refuse;
        logic can_elem;
        logic can_empty;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/sorted_stream_merge_core.sv =====
`timescale 1ns / 1ps
// Top level of the sorted stream merge block: two-way merge of ascending sequences.
// Depends on ssm_pkg, ssm_ctrl and ssm_datapath.
//
// Input request: s_tuser carries the op (push to first, push to second, end
// first, end second), s_tdata the signed element value. Result request:
// m_tdata the merged value, m_tlast the final element of a merge, m_tuser the
// status (element, both sequences empty, push refused).
// Elements wait in two FIFOs of BUFFER_DEPTH entries each. One element is held
// back until both sequences have ended, so the final one can carry m_tlast.
// Flow: an accepted request passes a fetch step (head read from the FIFO
// memory) before it is evaluated; each result it releases takes a fetch step
// and an evaluate step (head read, then compare and load of the output
// register), and shows on m_tvalid from that register. s_tready returns once
// no further result can be decided. A refused push is loaded as its status
// result from a refuse state, once the output register is free.
// The output register holds a result while m_tready is low; the next request
// is taken meanwhile, and evaluation stalls only when a further result is due.
// Reset (aresetn low, synchronous) empties both FIFOs, clears the end flags
// and drops m_tvalid. No clearing pass is needed.
module sorted_stream_merge_core #(
    parameter int BUFFER_DEPTH = ssm_pkg::DEFAULT_BUFFER_DEPTH,
    parameter int VALUE_WIDTH  = ssm_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ssm_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [ssm_pkg::OP_W-1:0]    s_tuser,   // [1:0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ssm_pkg::DATA_W-1:0]  m_tdata,   // [31:0] out_value
    output logic                        m_tlast,
    output logic [ssm_pkg::STAT_W-1:0]  m_tuser    // [1:0] status
);
    import ssm_pkg::*;

    cmd_t  cmd;
    stat_t st;

    ssm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ssm_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// ===== rtl/ssm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sorted stream merge block.
// Depends on ssm_pkg; drives ssm_datapath through cmd_t and reads stat_t.
module ssm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ssm_pkg::stat_t st,
    output ssm_pkg::cmd_t  cmd
);
    import ssm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (st.refuse) begin
                        state_next = ST_REFUSE;
                    end else begin
                        cmd.accept = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REFUSE: begin
                if (st.out_free) begin
                    cmd.load_refuse = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FETCH: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (st.can_elem) begin
                    if (st.out_free) begin
                        cmd.load_elem = 1'b1;
                        state_next    = ST_FETCH;
                    end
                end else if (st.can_empty) begin
                    if (st.out_free) begin
                        cmd.load_empty = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ssm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the sorted stream merge block: two FIFOs, head compare, output register.
// Depends on ssm_pkg; commanded by ssm_ctrl.
module ssm_datapath #(
    parameter int BUFFER_DEPTH = ssm_pkg::DEFAULT_BUFFER_DEPTH,
    parameter int VALUE_WIDTH  = ssm_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ssm_pkg::DATA_W-1:0]  s_tdata,
    input  logic [ssm_pkg::OP_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ssm_pkg::DATA_W-1:0]  m_tdata,
    output logic                        m_tlast,
    output logic [ssm_pkg::STAT_W-1:0]  m_tuser,
    input  ssm_pkg::cmd_t               cmd,
    output ssm_pkg::stat_t              st
);
    import ssm_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(BUFFER_DEPTH);

    logic [VALUE_WIDTH-1:0] mem_f [BUFFER_DEPTH];
    logic [VALUE_WIDTH-1:0] mem_s [BUFFER_DEPTH];

    logic [AW-1:0]          rd_f_reg, rd_s_reg, wr_f_reg, wr_s_reg;
    logic [CW-1:0]          cnt_f_reg, cnt_s_reg;
    logic                   done_f_reg, done_s_reg;
    logic [VALUE_WIDTH-1:0] head_f_reg, head_s_reg;

    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_last_reg;
    status_t                out_status_reg;

    logic [XW-1:0]          in_ext, out_ext;
    logic [VALUE_WIDTH-1:0] in_value;
    op_t                    op;
    logic                   push_f, push_s;
    logic                   has_f, has_s, both;
    logic [CW:0]            total;
    logic                   take_f, can_take, last_elem;

    assign op       = op_t'(s_tuser);
    assign in_ext   = XW'(s_tdata);
    assign in_value = in_ext[VALUE_WIDTH-1:0];
    assign push_f   = cmd.accept && (op == OP_PUSH_FIRST);
    assign push_s   = cmd.accept && (op == OP_PUSH_SECOND);

    assign has_f = (cnt_f_reg != '0);
    assign has_s = (cnt_s_reg != '0);
    assign both  = done_f_reg && done_s_reg;
    assign total = {1'b0, cnt_f_reg} + {1'b0, cnt_s_reg};

    always_comb begin
        take_f   = 1'b0;
        can_take = 1'b0;
        if (has_f && has_s) begin
            can_take = 1'b1;
            take_f   = ($signed(head_f_reg) <= $signed(head_s_reg));
        end else if (has_f && done_s_reg) begin
            can_take = 1'b1;
            take_f   = 1'b1;
        end else if (has_s && done_f_reg) begin
            can_take = 1'b1;
        end
    end

    assign last_elem = both && (total == (CW+1)'(1));

    always_comb begin
        st.refuse    = 1'b0;
        case (op)
            OP_PUSH_FIRST:  st.refuse = done_f_reg || (cnt_f_reg == FULL_CNT);
            OP_PUSH_SECOND: st.refuse = done_s_reg || (cnt_s_reg == FULL_CNT);
            default:        st.refuse = 1'b0;
        endcase
        st.can_elem  = can_take && (both || (total >= (CW+1)'(2)));
        st.can_empty = both && !has_f && !has_s;
        st.out_free  = !out_valid_reg || m_tready;
    end

    // storage and head read
    always_ff @(posedge aclk) begin
        if (push_f) begin
            mem_f[wr_f_reg] <= in_value;
        end
        if (push_s) begin
            mem_s[wr_s_reg] <= in_value;
        end
        head_f_reg <= mem_f[rd_f_reg];
        head_s_reg <= mem_s[rd_s_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_f_reg   <= '0;
            rd_s_reg   <= '0;
            wr_f_reg   <= '0;
            wr_s_reg   <= '0;
            cnt_f_reg  <= '0;
            cnt_s_reg  <= '0;
            done_f_reg <= 1'b0;
            done_s_reg <= 1'b0;
        end else begin
            if (push_f) begin
                wr_f_reg  <= (wr_f_reg == LAST_ADDR) ? '0 : wr_f_reg + 1'b1;
                cnt_f_reg <= cnt_f_reg + 1'b1;
            end
            if (push_s) begin
                wr_s_reg  <= (wr_s_reg == LAST_ADDR) ? '0 : wr_s_reg + 1'b1;
                cnt_s_reg <= cnt_s_reg + 1'b1;
            end
            if (cmd.accept && (op == OP_END_FIRST)) begin
                done_f_reg <= 1'b1;
            end
            if (cmd.accept && (op == OP_END_SECOND)) begin
                done_s_reg <= 1'b1;
            end
            if (cmd.load_elem) begin
                if (take_f) begin
                    rd_f_reg  <= (rd_f_reg == LAST_ADDR) ? '0 : rd_f_reg + 1'b1;
                    cnt_f_reg <= cnt_f_reg - 1'b1;
                end else begin
                    rd_s_reg  <= (rd_s_reg == LAST_ADDR) ? '0 : rd_s_reg + 1'b1;
                    cnt_s_reg <= cnt_s_reg - 1'b1;
                end
                if (last_elem) begin
                    done_f_reg <= 1'b0;
                    done_s_reg <= 1'b0;
                end
            end
            if (cmd.load_empty) begin
                done_f_reg <= 1'b0;
                done_s_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_elem || cmd.load_empty || cmd.load_refuse) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_elem) begin
            out_value_reg  <= take_f ? head_f_reg : head_s_reg;
            out_last_reg   <= last_elem;
            out_status_reg <= STAT_ELEM;
        end else if (cmd.load_empty) begin
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= STAT_EMPTY;
        end else if (cmd.load_refuse) begin
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= STAT_REFUSED;
        end
    end

    assign out_ext  = XW'(out_value_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ext[DATA_W-1:0];
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/ssm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for sorted_stream_merge_core, attached by bind.
// Depends on ssm_pkg.
module ssm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ssm_pkg::DATA_W-1:0]  m_tdata,
    input logic                        m_tlast,
    input logic [ssm_pkg::STAT_W-1:0]  m_tuser
);
    import ssm_pkg::*;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result request changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_ELEM) || (m_tuser == STAT_EMPTY)
            || (m_tuser == STAT_REFUSED))
        else $error("reserved status code");

    a_status_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_ELEM) |-> !m_tlast && (m_tdata == '0))
        else $error("status result carries data or last mark");

    a_no_input_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken in back-to-back cycles");

endmodule

bind sorted_stream_merge_core ssm_checker u_ssm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
